>>> rtl/stereo_biquad_preemphasis_filter_core_defines.svh
// Assertion macros shared by the checker of the stereo biquad filter core.
// Needs nothing else; the using scope supplies clk_i and rst_ni.
`ifndef STEREO_BIQUAD_PREEMPHASIS_FILTER_CORE_DEFINES_SVH
`define STEREO_BIQUAD_PREEMPHASIS_FILTER_CORE_DEFINES_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define SBPF_ASSERT_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("sbpf assertion failed");

// Concurrent assertion on the block clock and reset.
`define SBPF_ASSERT(lbl, prop) \
  `SBPF_ASSERT_CLK(lbl, clk_i, rst_ni, prop)

`endif

>>> rtl/sbpf_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the stereo biquad filter core.
// Depends on nothing; used by the interface users, the memory, the top level and the checker.
package sbpf_pkg;

  localparam int unsigned CHANNELS_DEF = 2;
  localparam int unsigned SAMPLE_W     = 16;
  localparam int unsigned COEF_W       = 32;
  localparam int unsigned Y_W          = 32;
  localparam int unsigned FRAC_Y       = 8;
  localparam int unsigned RND_SHIFT    = 16;
  localparam int unsigned CFG_IDX_W    = 3;
  localparam int unsigned FF_W         = COEF_W + SAMPLE_W;
  localparam int unsigned FB_W         = COEF_W + Y_W - FRAC_Y;
  localparam int unsigned ACC_W        = FB_W + 2;
  localparam int unsigned YPRE_W       = ACC_W - RND_SHIFT;
  localparam int unsigned CLAMP_W      = SAMPLE_W + FRAC_Y;

  localparam logic signed [ACC_W-1:0]  RND_HALF = ACC_W'(1) <<< (RND_SHIFT - 1);
  localparam logic signed [YPRE_W-1:0] Y_MAX    = (YPRE_W'(1) <<< (Y_W - 1)) - YPRE_W'(1);
  localparam logic signed [YPRE_W-1:0] Y_MIN    = -(YPRE_W'(1) <<< (Y_W - 1));
  localparam logic signed [YPRE_W-1:0] CL_MAX   = YPRE_W'(32767 * 256);
  localparam logic signed [YPRE_W-1:0] CL_MIN   = YPRE_W'(-32768 * 256);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLE = 3'd0,
    CFG_B0     = 3'd1,
    CFG_B1     = 3'd2,
    CFG_B2     = 3'd3,
    CFG_A1     = 3'd4,
    CFG_A2     = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic                       channel;
    logic signed [SAMPLE_W-1:0] sample_in;
    logic                       last_in_buffer;
  } in_item_t;

  typedef struct packed {
    logic                       channel_out;
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       last_out;
  } out_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] x1;
    logic signed [SAMPLE_W-1:0] x2;
    logic signed [Y_W-1:0]      y1;
    logic signed [Y_W-1:0]      y2;
  } hist_t;

  typedef struct packed {
    logic rd_en;
    logic we;
  } mem_ctl_t;

endpackage

>>> rtl/sbpf_stream_if.sv
`timescale 1ns / 1ps
// Valid/ready stream channel carrying one item of a given type.
// Depends on nothing; the item type is supplied by the instantiating scope.
interface sbpf_stream_if #(
  parameter type item_t = logic
) ();
  logic  valid;
  logic  ready;
  item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/sbpf_hist_mem.sv
`timescale 1ns / 1ps
// Per-channel history memory: one synchronous write port, one registered read port.
// Depends on sbpf_pkg; entries never written since reset read as zero.
module sbpf_hist_mem #(
  parameter int unsigned DEPTH = sbpf_pkg::CHANNELS_DEF,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  sbpf_pkg::mem_ctl_t ctl_i,
  input  logic [AW-1:0]    rd_addr_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  sbpf_pkg::hist_t  wr_data_i,
  output sbpf_pkg::hist_t  rd_data_o
);
  import sbpf_pkg::*;

  hist_t            mem_q [DEPTH];
  logic [DEPTH-1:0] vld_q;
  hist_t            rd_q;
  logic             rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.we) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (ctl_i.rd_en) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (ctl_i.we) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (ctl_i.rd_en) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_q : '0;

endmodule

>>> rtl/stereo_biquad_preemphasis_filter_core.sv
`timescale 1ns / 1ps
// Top level of the stereo biquad pre-emphasis filter core.
// Depends on sbpf_pkg, sbpf_stream_if and sbpf_hist_mem.
//
// Each input item is a 16-bit sample tagged with its channel; it runs through that
// channel's direct form I biquad (coefficients in Q8.24, output history in Q24.8)
// and leaves clamped to 16 bits, in order, one result per item. The block takes one
// item per clock unless it stalls. Of two filtered items of the same channel in a row,
// the second waits at the input for the first one's history write-back: the
// per-channel history memory is read at acceptance, multiplied in the next stage and
// accumulated and written back in the stage after that. A result passes through stage 1,
// stage 2 and the output register. The output register has a skid stage behind it;
// while the skid stage holds a result, no items enter. With enable off, or for a
// channel beyond the configured count, samples pass through and no history changes.
module stereo_biquad_preemphasis_filter_core #(
  parameter int unsigned CHANNELS = sbpf_pkg::CHANNELS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  sbpf_stream_if.sink                        in_i,
  sbpf_stream_if.source                      out_o,
  input  logic                               cfg_we_i,
  input  logic [sbpf_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [sbpf_pkg::COEF_W-1:0]        cfg_wdata_i
);
  import sbpf_pkg::*;

  localparam int unsigned AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic                     enable_q;
  logic signed [COEF_W-1:0] coef_b0_q, coef_b1_q, coef_b2_q, coef_a1_q, coef_a2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q  <= 1'b0;
      coef_b0_q <= '0;
      coef_b1_q <= '0;
      coef_b2_q <= '0;
      coef_a1_q <= '0;
      coef_a2_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_ENABLE: enable_q  <= cfg_wdata_i[0];
        CFG_B0:     coef_b0_q <= cfg_wdata_i;
        CFG_B1:     coef_b1_q <= cfg_wdata_i;
        CFG_B2:     coef_b2_q <= cfg_wdata_i;
        CFG_A1:     coef_a1_q <= cfg_wdata_i;
        CFG_A2:     coef_a2_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  in_item_t in_item;
  logic     in_upd, hazard, adv, in_acc;
  logic     skid_vld_q;

  logic                       s1_vld_q, s1_ch_q, s1_last_q, s1_upd_q;
  logic signed [SAMPLE_W-1:0] s1_x_q;

  assign in_item = in_i.data;
  assign in_upd  = enable_q && (32'(in_item.channel) < CHANNELS);
  assign adv     = !skid_vld_q;
  assign hazard  = s1_vld_q && s1_upd_q && in_upd && (s1_ch_q == in_item.channel);
  assign in_i.ready = adv && !hazard;
  assign in_acc  = in_i.valid && in_i.ready;

  mem_ctl_t mem_ctl;
  hist_t    mem_rd_data, wb_d, wb_q;
  logic     wb_vld_q, wb_ch_q;

  logic                       s2_vld_q, s2_ch_q, s2_last_q, s2_upd_q;
  logic signed [SAMPLE_W-1:0] s2_x_q, s2_x1_q;
  logic signed [Y_W-1:0]      s2_y1_q;
  logic signed [FF_W-1:0]     s2_p0_q, s2_p1_q, s2_p2_q;
  logic signed [FB_W-1:0]     s2_f1_q, s2_f2_q;

  assign mem_ctl.rd_en = in_acc && in_upd;
  assign mem_ctl.we    = adv && s2_vld_q && s2_upd_q;

  sbpf_hist_mem #(
    .DEPTH (CHANNELS),
    .AW    (AW)
  ) u_hist_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (mem_ctl),
    .rd_addr_i (AW'(in_item.channel)),
    .wr_addr_i (AW'(s2_ch_q)),
    .wr_data_i (wb_d),
    .rd_data_o (mem_rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      wb_vld_q <= 1'b0;
    end else if (adv) begin
      s1_vld_q <= in_acc;
      s2_vld_q <= s1_vld_q;
      wb_vld_q <= mem_ctl.we;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && in_acc) begin
      s1_ch_q   <= in_item.channel;
      s1_x_q    <= in_item.sample_in;
      s1_last_q <= in_item.last_in_buffer;
      s1_upd_q  <= in_upd;
    end
  end

  hist_t                    hist_s1;
  logic signed [FF_W-1:0]   p0_d, p1_d, p2_d;
  logic signed [2*Y_W-1:0]  pa1, pa2;

  assign hist_s1 = (wb_vld_q && (wb_ch_q == s1_ch_q)) ? wb_q : mem_rd_data;
  assign p0_d = FF_W'(coef_b0_q) * FF_W'(s1_x_q);
  assign p1_d = FF_W'(coef_b1_q) * FF_W'($signed(hist_s1.x1));
  assign p2_d = FF_W'(coef_b2_q) * FF_W'($signed(hist_s1.x2));
  assign pa1  = (2*Y_W)'(coef_a1_q) * (2*Y_W)'($signed(hist_s1.y1));
  assign pa2  = (2*Y_W)'(coef_a2_q) * (2*Y_W)'($signed(hist_s1.y2));

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_ch_q   <= s1_ch_q;
      s2_last_q <= s1_last_q;
      s2_upd_q  <= s1_upd_q;
      s2_x_q    <= s1_x_q;
      s2_x1_q   <= hist_s1.x1;
      s2_y1_q   <= hist_s1.y1;
      s2_p0_q   <= p0_d;
      s2_p1_q   <= p1_d;
      s2_p2_q   <= p2_d;
      s2_f1_q   <= FB_W'(pa1 >>> FRAC_Y);
      s2_f2_q   <= FB_W'(pa2 >>> FRAC_Y);
    end
  end

  logic signed [ACC_W-1:0]    acc;
  logic signed [YPRE_W-1:0]   y_pre;
  logic signed [Y_W-1:0]      y_new;
  logic signed [CLAMP_W-1:0]  cl;
  logic signed [SAMPLE_W-1:0] q, res_sample;

  always_comb begin
    acc = ACC_W'(s2_p0_q) + ACC_W'(s2_p1_q) + ACC_W'(s2_p2_q)
        - ACC_W'(s2_f1_q) - ACC_W'(s2_f2_q) + RND_HALF;
    y_pre = YPRE_W'(acc >>> RND_SHIFT);
    if (y_pre > Y_MAX) begin
      y_new = Y_W'(Y_MAX);
    end else if (y_pre < Y_MIN) begin
      y_new = Y_W'(Y_MIN);
    end else begin
      y_new = Y_W'(y_pre);
    end
    if (y_pre > CL_MAX) begin
      cl = CLAMP_W'(CL_MAX);
    end else if (y_pre < CL_MIN) begin
      cl = CLAMP_W'(CL_MIN);
    end else begin
      cl = CLAMP_W'(y_pre);
    end
    q = cl[CLAMP_W-1:FRAC_Y];
    if (cl[CLAMP_W-1] && (|cl[FRAC_Y-1:0])) begin
      q = q + SAMPLE_W'(1);
    end
    res_sample = s2_upd_q ? q : s2_x_q;
  end

  assign wb_d = '{x1: s2_x_q, x2: s2_x1_q, y1: y_new, y2: s2_y1_q};

  always_ff @(posedge clk_i) begin
    if (adv) begin
      wb_ch_q <= s2_ch_q;
      wb_q    <= wb_d;
    end
  end

  out_item_t res, out_q, out_d, skid_q, skid_d;
  logic      res_vld, out_taken, out_vld_q, out_vld_d, skid_vld_d;

  assign res       = '{channel_out: s2_ch_q, sample_out: res_sample, last_out: s2_last_q};
  assign res_vld   = adv && s2_vld_q;
  assign out_taken = out_vld_q && out_o.ready;

  always_comb begin
    out_vld_d  = out_vld_q;
    out_d      = out_q;
    skid_vld_d = skid_vld_q;
    skid_d     = skid_q;
    if (skid_vld_q) begin
      if (out_taken) begin
        out_d      = skid_q;
        skid_vld_d = 1'b0;
      end
    end else if (res_vld) begin
      if (!out_vld_q || out_taken) begin
        out_vld_d = 1'b1;
        out_d     = res;
      end else begin
        skid_vld_d = 1'b1;
        skid_d     = res;
      end
    end else if (out_taken) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_o.valid = out_vld_q;
  assign out_o.data  = out_q;

endmodule

>>> rtl/sbpf_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the stereo biquad filter core, bound to the top level.
// Depends on sbpf_pkg and the assertion macros header.
`include "stereo_biquad_preemphasis_filter_core_defines.svh"

module sbpf_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_i,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input sbpf_pkg::out_item_t out_data_i
);
  import sbpf_pkg::*;

  localparam logic [2:0] MAX_INFLIGHT = 3'd4;

  logic       in_acc, out_acc;
  logic [2:0] cnt_q, cnt_d;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;
  assign cnt_d   = cnt_q + 3'(in_acc) - 3'(out_acc);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  `SBPF_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i)
  `SBPF_ASSERT(a_out_stable, out_valid_i && !out_ready_i |=> $stable(out_data_i))
  `SBPF_ASSERT(a_inflight_max, cnt_q <= MAX_INFLIGHT)
  `SBPF_ASSERT(a_no_phantom, cnt_q == 3'd0 |-> !out_valid_i)

endmodule

bind stereo_biquad_preemphasis_filter_core sbpf_checker u_sbpf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);

>>> bench/sbpf_filter_checker.sv
`timescale 1ns / 1ps
// Checker for the stereo biquad filter core: tracks the configuration writes, predicts
// each result item from the accepted input items and compares it with the output.
// Depends on sbpf_pkg.
module sbpf_filter_checker #(
  parameter int unsigned CHANNELS = sbpf_pkg::CHANNELS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_ready_i,
  input  sbpf_pkg::in_item_t             in_data_i,
  input  logic                           out_valid_i,
  input  logic                           out_ready_i,
  input  sbpf_pkg::out_item_t            out_data_i,
  input  logic                           cfg_we_i,
  input  logic [sbpf_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [sbpf_pkg::COEF_W-1:0]    cfg_wdata_i,
  output int unsigned                    pending_o,
  output int unsigned                    err_count_o
);
  import sbpf_pkg::*;

  logic                       filt_en;
  longint                     b0, b1, b2, a1, a2;
  logic signed [SAMPLE_W-1:0] x_hist [CHANNELS][2];
  logic signed [Y_W-1:0]      y_hist [CHANNELS][2];
  out_item_t                  expected_samples [$];
  out_item_t                  want;
  int unsigned                errors;

  function automatic out_item_t filter_sample(in_item_t it);
    longint      x;
    longint      acc;
    longint      y;
    longint      shown;
    int unsigned ch;
    out_item_t   res;
    ch                 = it.channel;
    x                  = it.sample_in;
    res.channel_out    = it.channel;
    res.last_out       = it.last_in_buffer;
    res.sample_out     = it.sample_in;
    if (filt_en && ch < CHANNELS) begin
      acc = b0 * x + b1 * longint'(x_hist[ch][0]) + b2 * longint'(x_hist[ch][1]);
      acc = acc - ((a1 * longint'(y_hist[ch][0])) >>> 8);
      acc = acc - ((a2 * longint'(y_hist[ch][1])) >>> 8);
      y   = (acc + 64'sd32768) >>> 16;
      if (y > 64'sd2147483647) begin
        y = 64'sd2147483647;
      end else if (y < -64'sd2147483648) begin
        y = -64'sd2147483648;
      end
      x_hist[ch][1] = x_hist[ch][0];
      x_hist[ch][0] = it.sample_in;
      y_hist[ch][1] = y_hist[ch][0];
      y_hist[ch][0] = y[Y_W-1:0];
      shown = y;
      if (shown > 64'sd8388352) begin
        shown = 64'sd8388352;
      end else if (shown < -64'sd8388608) begin
        shown = -64'sd8388608;
      end
      shown          = (shown < 0) ? -((-shown) >>> 8) : (shown >>> 8);
      res.sample_out = shown[SAMPLE_W-1:0];
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filt_en = 1'b0;
      b0 = 0;
      b1 = 0;
      b2 = 0;
      a1 = 0;
      a2 = 0;
      for (int c = 0; c < CHANNELS; c++) begin
        x_hist[c][0] = '0;
        x_hist[c][1] = '0;
        y_hist[c][0] = '0;
        y_hist[c][1] = '0;
      end
      expected_samples.delete();
      errors = 0;
      pending_o   <= 0;
      err_count_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_samples.size() == 0) begin
          $error("unexpected result item: channel_out %0d sample_out %0d last_out %0d",
                 out_data_i.channel_out, $signed(out_data_i.sample_out), out_data_i.last_out);
          errors++;
        end else begin
          want = expected_samples.pop_front();
          if (out_data_i.channel_out !== want.channel_out) begin
            $error("channel_out mismatch: expected %0d, got %0d",
                   want.channel_out, out_data_i.channel_out);
            errors++;
          end
          if (out_data_i.sample_out !== want.sample_out) begin
            $error("sample_out mismatch: expected %0d, got %0d",
                   $signed(want.sample_out), $signed(out_data_i.sample_out));
            errors++;
          end
          if (out_data_i.last_out !== want.last_out) begin
            $error("last_out mismatch: expected %0d, got %0d",
                   want.last_out, out_data_i.last_out);
            errors++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        expected_samples.push_back(filter_sample(in_data_i));
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_ENABLE: filt_en = cfg_wdata_i[0];
          CFG_B0:     b0 = longint'(signed'(cfg_wdata_i));
          CFG_B1:     b1 = longint'(signed'(cfg_wdata_i));
          CFG_B2:     b2 = longint'(signed'(cfg_wdata_i));
          CFG_A1:     a1 = longint'(signed'(cfg_wdata_i));
          CFG_A2:     a2 = longint'(signed'(cfg_wdata_i));
          default: ;
        endcase
      end
      pending_o   <= expected_samples.size();
      err_count_o <= errors;
    end
  end

endmodule

>>> bench/tb_stereo_biquad_preemphasis_filter_core.sv
`timescale 1ns / 1ps
// Testbench top for the stereo biquad filter core: clock, reset, configuration phases,
// directed and random sample items, random output stalls and the final verdict.
// Depends on sbpf_pkg, sbpf_stream_if, the core and sbpf_filter_checker.
module tb_stereo_biquad_preemphasis_filter_core;
  import sbpf_pkg::*;

  localparam logic [COEF_W-1:0] ONE_Q24   = 32'h0100_0000;
  localparam logic [COEF_W-1:0] COEF_MAX  = 32'h7FFF_FFFF;
  localparam logic [COEF_W-1:0] COEF_MIN  = 32'h8000_0000;
  localparam int unsigned       STALL_MAX = 5000;
  localparam int unsigned       PHASES    = 7;
  localparam int unsigned       PHASE_LEN = 150;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 rcv_ready = 1'b0;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [COEF_W-1:0]    cfg_wdata;
  int unsigned          pending;
  int unsigned          err_count;
  int unsigned          stall_cycles = 0;
  int unsigned          send_idle_pct = 11;
  int unsigned          recv_idle_pct = 61;

  sbpf_stream_if #(.item_t(in_item_t))  in_ch ();
  sbpf_stream_if #(.item_t(out_item_t)) out_ch ();

  assign out_ch.ready = rcv_ready;

  stereo_biquad_preemphasis_filter_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_ch),
    .out_o       (out_ch),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  sbpf_filter_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch.valid),
    .in_ready_i  (in_ch.ready),
    .in_data_i   (in_ch.data),
    .out_valid_i (out_ch.valid),
    .out_ready_i (out_ch.ready),
    .out_data_i  (out_ch.data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .pending_o   (pending),
    .err_count_o (err_count)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    rcv_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we) begin
      stall_cycles <= 0;
    end else if (stall_cycles + 1 >= STALL_MAX) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send_sample(input logic ch, input logic [SAMPLE_W-1:0] s, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= '{channel: ch, sample_in: s, last_in_buffer: last};
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  // Returns once every predicted result item has been taken from the block.
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic reg_write(input cfg_idx_e idx, input logic [COEF_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk_i);
  endtask

  task automatic program_filter(input logic en, input logic [COEF_W-1:0] c_b0,
                                input logic [COEF_W-1:0] c_b1, input logic [COEF_W-1:0] c_b2,
                                input logic [COEF_W-1:0] c_a1, input logic [COEF_W-1:0] c_a2);
    reg_write(CFG_ENABLE, {{(COEF_W-1){1'b0}}, en});
    reg_write(CFG_B0, c_b0);
    reg_write(CFG_B1, c_b1);
    reg_write(CFG_B2, c_b2);
    reg_write(CFG_A1, c_a1);
    reg_write(CFG_A2, c_a2);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    if ($urandom_range(3) == 0) begin
      case ($urandom_range(3))
        0:       return 16'h7FFF;
        1:       return 16'h8000;
        2:       return 16'h0000;
        default: return 16'hFFFF;
      endcase
    end
    return SAMPLE_W'($urandom);
  endfunction

  initial begin
    logic next_ch;
    logic ch;
    in_ch.valid <= 1'b0;
    in_ch.data  <= '0;
    cfg_we      <= 1'b0;
    cfg_idx     <= CFG_ENABLE;
    cfg_wdata   <= '0;
    next_ch = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Out of reset the filter is off, so samples pass through unchanged.
    send_sample(1'b0, 16'h7FFF, 1'b1);
    send_sample(1'b1, 16'h8000, 1'b0);
    send_sample(1'b0, 16'h0000, 1'b0);
    send_sample(1'b1, 16'hFFFF, 1'b1);
    drain();

    program_filter(1'b1, ONE_Q24, '0, '0, '0, '0);
    send_sample(1'b0, 16'h7FFF, 1'b0);
    send_sample(1'b1, 16'h8000, 1'b1);
    send_sample(1'b0, 16'hFFFF, 1'b0);
    send_sample(1'b1, 16'h0001, 1'b0);
    drain();

    program_filter(1'b1, 32'h0200_0000, 32'hFE80_0000, 32'h0010_0000,
                   32'hFF40_0000, 32'h0020_0000);
    repeat (3) send_sample(1'b0, 16'h7FFF, 1'b0);
    repeat (3) send_sample(1'b1, 16'h8000, 1'b0);
    send_sample(1'b0, 16'h8000, 1'b1);
    send_sample(1'b0, 16'h0000, 1'b0);
    drain();

    // Extreme coefficients drive the output history into saturation.
    program_filter(1'b1, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
    send_sample(1'b0, 16'h7FFF, 1'b0);
    send_sample(1'b0, 16'h7FFF, 1'b1);
    send_sample(1'b1, 16'h8000, 1'b0);
    send_sample(1'b1, 16'h0001, 1'b0);
    drain();

    program_filter(1'b1, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN);
    send_sample(1'b0, 16'h8000, 1'b0);
    send_sample(1'b1, 16'h7FFF, 1'b1);
    send_sample(1'b0, 16'h0000, 1'b0);
    drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph == 3) begin
        send_idle_pct = 61;
        recv_idle_pct = 11;
      end
      if (ph == 5) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (ph)
        0, 5: program_filter(1'b1,
                             32'($urandom_range(32'h0300_0000, 32'h0080_0000)),
                             -32'($urandom_range(32'h0200_0000, 32'h0080_0000)),
                             32'($urandom_range(32'h0100_0000, 0)),
                             -32'($urandom_range(32'h01C0_0000, 32'h0080_0000)),
                             32'($urandom_range(32'h00C0_0000, 0)));
        1, 6: program_filter(1'b1, $urandom, $urandom, $urandom, $urandom, $urandom);
        2:    program_filter(1'b1, COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN, COEF_MAX);
        3:    program_filter(1'b0, $urandom, $urandom, $urandom, $urandom, $urandom);
        default: program_filter(1'b1, COEF_MIN, COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN);
      endcase
      for (int n = 0; n < PHASE_LEN; n++) begin
        // Mostly interleaved stereo frames, with some runs on one channel.
        if ($urandom_range(9) < 3) begin
          ch = 1'($urandom);
        end else begin
          ch = next_ch;
        end
        next_ch = ~ch;
        send_sample(ch, pick_sample(), ($urandom_range(15) == 0));
      end
      drain();
    end

    repeat (8) @(posedge clk_i);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl
rtl/sbpf_pkg.sv
rtl/sbpf_stream_if.sv
rtl/sbpf_hist_mem.sv
rtl/stereo_biquad_preemphasis_filter_core.sv
rtl/sbpf_checker.sv
bench/sbpf_filter_checker.sv
bench/tb_stereo_biquad_preemphasis_filter_core.sv
